// ----- rtl/sbc_pkg.sv -----
// Shared constants and the per-item carry record of the sphere-box contact pipeline.
package sbc_pkg;

  localparam int COORD_FRAC_BITS  = 16;
  localparam int NORMAL_FRAC_BITS = 14;

  // Largest distance that still counts as near zero (distance * 10000 <= 2^COORD_FRAC_BITS).
  localparam int NEAR_MAX = (1 << COORD_FRAC_BITS) / 10000;

  localparam int CW  = 32;
  localparam int RW  = 31;
  localparam int SQW = 2 * RW;
  localparam int QW  = NORMAL_FRAC_BITS + 1;
  localparam int DVW = RW + NORMAL_FRAC_BITS + 1;
  localparam int NW  = 16;

  typedef struct packed {
    logic                   miss;
    logic [2:0][CW-1:0]     pt;
    logic [2:0][RW-1:0]     mag;
    logic [2:0]             neg;
    logic [RW-1:0]          rad;
  } carry_t;

endpackage

// ----- rtl/sphere_box_contact.sv -----
// Sphere against axis-aligned box contact test, fully pipelined.
//
// The input channel takes one sphere-box pair per word: center and box
// corners in signed Q16.16 and an unsigned Q16.16 radius. The result channel
// gives one word per input word: hit flag, closest box point, Q1.14 unit
// normal and depth. A miss returns all zeros. Both channels use valid and
// stall; a word moves on a clock edge where valid is high and stall is low.
//
// From acceptance to the valid result: one stage clamps, one squares, one
// sums and compares, 31 stages resolve the integer square root one bit each,
// 15 stages resolve the three normal quotients one bit each, and one stage
// forms the result register.
// Throughput is one word per cycle while the result side does not stall.
//
// All stages advance together. When the result register holds a word that
// the receiver stalls, the whole pipeline holds and in_stall is raised;
// nothing is lost or repeated. Synchronous reset clears every valid bit.
module sphere_box_contact (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       in_sphere_x,
  input  logic signed [31:0]       in_sphere_y,
  input  logic signed [31:0]       in_sphere_z,
  input  logic        [30:0]       in_sphere_radius,
  input  logic signed [31:0]       in_box_min_x,
  input  logic signed [31:0]       in_box_min_y,
  input  logic signed [31:0]       in_box_min_z,
  input  logic signed [31:0]       in_box_max_x,
  input  logic signed [31:0]       in_box_max_y,
  input  logic signed [31:0]       in_box_max_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [31:0]       out_contact_x,
  output logic signed [31:0]       out_contact_y,
  output logic signed [31:0]       out_contact_z,
  output logic signed [15:0]       out_normal_x,
  output logic signed [15:0]       out_normal_y,
  output logic signed [15:0]       out_normal_z,
  output logic        [30:0]       out_depth
);

  localparam int CW  = sbc_pkg::CW;
  localparam int RW  = sbc_pkg::RW;
  localparam int SQW = sbc_pkg::SQW;
  localparam int QW  = sbc_pkg::QW;
  localparam int DVW = sbc_pkg::DVW;
  localparam int NW  = sbc_pkg::NW;
  localparam int NF  = sbc_pkg::NORMAL_FRAC_BITS;

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign out_valid = out_valid_r;

  // Clamp stage.
  logic signed [CW-1:0] cen [3];
  logic signed [CW-1:0] lo  [3];
  logic signed [CW-1:0] hi  [3];
  logic signed [CW-1:0] clp [3];
  logic signed [CW:0]   dif [3];
  logic        [CW:0]   mg  [3];
  logic                 far;
  sbc_pkg::carry_t      c1_nxt;

  assign cen[0] = in_sphere_x;
  assign cen[1] = in_sphere_y;
  assign cen[2] = in_sphere_z;
  assign lo[0]  = in_box_min_x;
  assign lo[1]  = in_box_min_y;
  assign lo[2]  = in_box_min_z;
  assign hi[0]  = in_box_max_x;
  assign hi[1]  = in_box_max_y;
  assign hi[2]  = in_box_max_z;

  always_comb begin
    far = 1'b0;
    c1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      clp[i] = (cen[i] < lo[i]) ? lo[i] : cen[i];
      clp[i] = (clp[i] > hi[i]) ? hi[i] : clp[i];
      dif[i] = {cen[i][CW-1], cen[i]} - {clp[i][CW-1], clp[i]};
      mg[i]  = dif[i][CW] ? (CW+1)'(-dif[i]) : (CW+1)'(dif[i]);
      if (mg[i] >= {2'b00, in_sphere_radius}) begin
        far = 1'b1;
      end
      c1_nxt.pt[i]  = clp[i];
      c1_nxt.mag[i] = mg[i][RW-1:0];
      c1_nxt.neg[i] = dif[i][CW];
    end
    c1_nxt.miss = far;
    c1_nxt.rad  = in_sphere_radius;
  end

  logic            v1_r;
  sbc_pkg::carry_t c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      c1_r <= c1_nxt;
    end
  end

  // Square stage.
  logic            v2_r;
  sbc_pkg::carry_t c2_r;
  logic [SQW-1:0]  sq2_r [3];
  logic [SQW-1:0]  rr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
      c2_r <= c1_r;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= SQW'(c1_r.mag[i]) * SQW'(c1_r.mag[i]);
      end
      rr2_r <= SQW'(c1_r.rad) * SQW'(c1_r.rad);
    end
  end

  // Sum and compare stage feeds the square-root chain at index 0.
  logic [SQW+1:0]  d2_sum;
  sbc_pkg::carry_t c3_nxt;

  always_comb begin
    d2_sum = (SQW+2)'(sq2_r[0]) + (SQW+2)'(sq2_r[1]) + (SQW+2)'(sq2_r[2]);
    c3_nxt = c2_r;
    c3_nxt.miss = c2_r.miss || (d2_sum >= (SQW+2)'(rr2_r));
  end

  logic            sr_v_r    [RW+1];
  logic [SQW-1:0]  sr_rem_r  [RW+1];
  logic [RW-1:0]   sr_root_r [RW+1];
  sbc_pkg::carry_t sr_c_r    [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_v_r[0] <= 1'b0;
    end else if (en) begin
      sr_v_r[0]    <= v2_r;
      sr_rem_r[0]  <= d2_sum[SQW-1:0];
      sr_root_r[0] <= '0;
      sr_c_r[0]    <= c3_nxt;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic [SQW-1:0] trial;
    logic           ge;

    assign trial = (SQW'(sr_root_r[k]) << (B + 1)) + (SQW'(1) << (2 * B));
    assign ge    = sr_rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sr_v_r[k+1]    <= sr_v_r[k];
        sr_rem_r[k+1]  <= ge ? sr_rem_r[k] - trial : sr_rem_r[k];
        sr_root_r[k+1] <= ge ? (sr_root_r[k] | (RW'(1) << B)) : sr_root_r[k];
        sr_c_r[k+1]    <= sr_c_r[k];
      end
    end
  end

  // Normal division chain; index 0 is formed from the square-root result.
  logic [RW-1:0]   root_len;
  assign root_len = sr_root_r[RW];

  logic                    dv_v    [QW+1];
  logic [2:0][DVW-1:0]     dv_rem  [QW+1];
  logic [2:0][QW-1:0]      dv_quo  [QW+1];
  logic [RW-1:0]           dv_dist [QW+1];
  logic                    dv_near [QW+1];
  logic [RW-1:0]           dv_dep  [QW+1];
  sbc_pkg::carry_t         dv_c    [QW+1];

  always_comb begin
    dv_v[0]    = sr_v_r[RW];
    dv_dist[0] = root_len;
    dv_near[0] = root_len <= RW'(sbc_pkg::NEAR_MAX);
    dv_dep[0]  = sr_c_r[RW].rad - root_len;
    dv_c[0]    = sr_c_r[RW];
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = (DVW'(sr_c_r[RW].mag[i]) << NF) + DVW'(root_len >> 1);
      dv_quo[0][i] = '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [DVW-1:0] trial;

    assign trial = DVW'(dv_dist[j]) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1]    <= dv_v[j];
        dv_dist[j+1] <= dv_dist[j];
        dv_near[j+1] <= dv_near[j];
        dv_dep[j+1]  <= dv_dep[j];
        dv_c[j+1]    <= dv_c[j];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= trial) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - trial;
            dv_quo[j+1][i] <= dv_quo[j][i] | (QW'(1) << B);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_quo[j+1][i] <= dv_quo[j][i];
          end
        end
      end
    end
  end

  // Result register.
  logic signed [NW-1:0] nrm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_c[QW].neg[i]) begin
        nrm[i] = NW'(-$signed({1'b0, dv_quo[QW][i]}));
      end else begin
        nrm[i] = NW'({1'b0, dv_quo[QW][i]});
      end
    end
    if (dv_near[QW]) begin
      nrm[0] = NW'(1 << NF);
      nrm[1] = '0;
      nrm[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[QW];
      if (dv_c[QW].miss) begin
        out_hit       <= 1'b0;
        out_contact_x <= '0;
        out_contact_y <= '0;
        out_contact_z <= '0;
        out_normal_x  <= '0;
        out_normal_y  <= '0;
        out_normal_z  <= '0;
        out_depth     <= '0;
      end else begin
        out_hit       <= 1'b1;
        out_contact_x <= dv_c[QW].pt[0];
        out_contact_y <= dv_c[QW].pt[1];
        out_contact_z <= dv_c[QW].pt[2];
        out_normal_x  <= nrm[0];
        out_normal_y  <= nrm[1];
        out_normal_z  <= nrm[2];
        out_depth     <= dv_dep[QW];
      end
    end
  end

endmodule
